/* design/ipv4_fpt_pkg.sv */
// ----------------------------------------------------------------------------
// IPv4 fragment port tracker package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ipv4_fpt_pkg;

  localparam int unsigned TableSlots = 16;
  localparam int unsigned HoldLimit  = 8;
  localparam int unsigned SlotW      = $clog2(TableSlots);
  localparam int unsigned HoldW      = $clog2(HoldLimit);
  localparam int unsigned CountW     = $clog2(HoldLimit + 1);
  localparam int unsigned HeldDepth  = TableSlots * HoldLimit;
  localparam int unsigned HeldAddrW  = $clog2(HeldDepth);
  localparam logic [31:0] AgeTimeoutReset = 32'd1000000;

  localparam logic       OpFragment = 1'b0;
  localparam logic       OpAge      = 1'b1;
  localparam logic [1:0] KindFirst  = 2'd0;
  localparam logic [1:0] KindLater  = 2'd1;
  localparam logic [1:0] DispForward = 2'd0;
  localparam logic [1:0] DispDrop    = 2'd1;
  localparam logic [1:0] DispAged    = 2'd2;

  // datapath commands
  typedef struct packed {
    logic capture;   // latch input beat, start lookup
    logic decide;    // lookup result registered: apply update, form first result
    logic pop;       // read next held handle for release
    logic load_out;  // move formed result into output register
  } ctl_cmd_t;

  // datapath status
  typedef struct packed {
    logic has_first;   // a result is formed after decide
    logic more;        // held handles remain to be released
  } ctl_sts_t;

endpackage

/* design/ipv4_fragment_port_tracker_top.sv */
// ----------------------------------------------------------------------------
// IPv4 fragment port tracker
// Associative flow table that attaches transport ports to forwarded fragments.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one beat: a fragment arrival or an
// age check of one slot. Output channel (out_valid/out_ready) gives zero to
// nine result beats per input; last_of_run_o marks the final one.
// Config channel (cfg_valid/cfg_ready) writes age_timeout; always ready,
// write only while idle.
// One item at a time: capture, registered 16-way key compare, then update.
// An item steps through the Look, Decide and Route states before the next
// accept; a single result is loaded into the output register in Route.
// Each released handle adds Pop (held-memory read) and Wait (handoff) states.
// A stall on the output holds the output register and the sequencer.
// Reset empties the table and sets age_timeout to 1000000; no clearing pass.
// ----------------------------------------------------------------------------
module ipv4_fragment_port_tracker_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation_i,
  input  logic [1:0]  frag_kind_i,
  input  logic [15:0] packet_handle_i,
  input  logic [15:0] packet_ident_i,
  input  logic [31:0] source_address_i,
  input  logic [31:0] dest_address_i,
  input  logic [7:0]  protocol_number_i,
  input  logic [15:0] source_port_i,
  input  logic [15:0] dest_port_i,
  input  logic [31:0] now_time_i,
  input  logic [3:0]  slot_index_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_handle_o,
  output logic [1:0]  disposition_o,
  output logic [15:0] out_source_port_o,
  output logic [15:0] out_dest_port_o,
  output logic        last_of_run_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data_i
);
  ipv4_fpt_pkg::ctl_cmd_t cmd;
  ipv4_fpt_pkg::ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  ipv4_fpt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready, .out_valid, .out_ready,
    .cmd_o(cmd), .sts_i(sts)
  );

  ipv4_fpt_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i,
    .operation_i, .frag_kind_i, .packet_handle_i, .packet_ident_i,
    .source_address_i, .dest_address_i, .protocol_number_i, .source_port_i,
    .dest_port_i, .now_time_i, .slot_index_i, .out_handle_o, .disposition_o,
    .out_source_port_o, .out_dest_port_o, .last_of_run_o
  );

endmodule

/* design/ipv4_fpt_datapath.sv */
// ----------------------------------------------------------------------------
// IPv4 fragment port tracker datapath
// Slot table, key compare, held-handle memory and output register.
// ----------------------------------------------------------------------------
module ipv4_fpt_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ipv4_fpt_pkg::ctl_cmd_t cmd_i,
  output ipv4_fpt_pkg::ctl_sts_t sts_o,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 operation_i,
  input  logic [1:0]           frag_kind_i,
  input  logic [15:0]          packet_handle_i,
  input  logic [15:0]          packet_ident_i,
  input  logic [31:0]          source_address_i,
  input  logic [31:0]          dest_address_i,
  input  logic [7:0]           protocol_number_i,
  input  logic [15:0]          source_port_i,
  input  logic [15:0]          dest_port_i,
  input  logic [31:0]          now_time_i,
  input  logic [3:0]           slot_index_i,
  output logic [15:0]          out_handle_o,
  output logic [1:0]           disposition_o,
  output logic [15:0]          out_source_port_o,
  output logic [15:0]          out_dest_port_o,
  output logic                 last_of_run_o
);
  localparam int unsigned SW = ipv4_fpt_pkg::SlotW;
  localparam int unsigned CW = ipv4_fpt_pkg::CountW;
  localparam int unsigned NS = ipv4_fpt_pkg::TableSlots;

  logic [31:0] age_timeout_q;
  logic [NS-1:0] valid_q, first_q;
  logic [CW-1:0] count_q [NS];
  logic [23:0] keyp_q [NS];
  logic [31:0] src_q [NS];
  logic [31:0] dst_q [NS];
  logic [31:0] touch_q [NS];
  logic [31:0] ports_q [NS];
  logic [15:0] held_mem [ipv4_fpt_pkg::HeldDepth];

  // latched item
  logic        op_q;
  logic [1:0]  kind_q;
  logic [15:0] handle_q;
  logic [23:0] key_q;
  logic [31:0] isrc_q, idst_q, iports_q, now_q;
  logic [3:0]  sidx_q;

  // lookup results (registered)
  logic [NS-1:0] hit_q;
  logic [NS-1:0] free_q;

  // release state
  logic [SW-1:0] rs_q;
  logic [CW-1:0] rem_q;
  logic [1:0]    rdisp_q;
  logic [31:0]   rports_q;
  logic          more_q;
  logic [15:0]   hdata_q;

  // formed result
  logic          pend_q;
  logic [15:0]   ph_q;
  logic [1:0]    pd_q;
  logic [31:0]   pp_q;
  logic          pl_q;

  // output reg
  logic [15:0] oh_q; logic [1:0] od_q; logic [31:0] op_ports_q; logic ol_q;

  assign out_handle_o      = oh_q;
  assign disposition_o     = od_q;
  assign out_source_port_o = op_ports_q[31:16];
  assign out_dest_port_o   = op_ports_q[15:0];
  assign last_of_run_o     = ol_q;

  assign sts_o.has_first  = pend_q;
  assign sts_o.more       = more_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_timeout_q <= ipv4_fpt_pkg::AgeTimeoutReset;
    end else if (cfg_valid_i && cfg_ready_i) begin
      age_timeout_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= operation_i;
      kind_q   <= frag_kind_i;
      handle_q <= packet_handle_i;
      key_q    <= {packet_ident_i, protocol_number_i};
      isrc_q   <= source_address_i;
      idst_q   <= dest_address_i;
      iports_q <= {source_port_i, dest_port_i};
      now_q    <= now_time_i;
      sidx_q   <= slot_index_i;
    end
  end

  // parallel key compare, registered
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NS; i++) begin
      hit_q[i]  <= valid_q[i] && keyp_q[i] == key_q && src_q[i] == isrc_q &&
                   dst_q[i] == idst_q;
      free_q[i] <= !valid_q[i];
    end
  end

  // priority encode
  logic [SW-1:0] hit_idx, free_idx, s;
  logic          any_hit, any_free;
  always_comb begin
    hit_idx = '0; free_idx = '0; any_hit = 1'b0; any_free = 1'b0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (hit_q[i])  begin hit_idx  = SW'(i); any_hit  = 1'b1; end
      if (free_q[i]) begin free_idx = SW'(i); any_free = 1'b1; end
    end
    s = any_hit ? hit_idx : free_idx;
  end

  logic [SW-1:0] as;
  logic          age_ok, stale;
  logic [31:0]   adiff;
  always_comb begin
    as     = sidx_q[SW-1:0];
    age_ok = (32'(sidx_q) < NS) && valid_q[as];
    adiff  = now_q - touch_q[as];
    stale  = age_ok && now_q > touch_q[as] && adiff > age_timeout_q;
  end

  logic [ipv4_fpt_pkg::HeldAddrW-1:0] rd_addr, wr_addr;
  assign rd_addr = {rs_q, ipv4_fpt_pkg::HoldW'(rem_q - CW'(1))};
  assign wr_addr = {s, ipv4_fpt_pkg::HoldW'(count_q[s])};

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide && op_q == ipv4_fpt_pkg::OpFragment && (any_hit || any_free) &&
        kind_q == ipv4_fpt_pkg::KindLater && !(any_hit && first_q[s]) &&
        (!any_hit || count_q[s] < CW'(ipv4_fpt_pkg::HoldLimit))) begin
      held_mem[wr_addr] <= handle_q;
    end
    if (cmd_i.pop) hdata_q <= held_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide && op_q == ipv4_fpt_pkg::OpFragment && (any_hit || any_free)) begin
      if (!any_hit) begin
        keyp_q[s] <= key_q; src_q[s] <= isrc_q; dst_q[s] <= idst_q;
      end
      touch_q[s] <= now_q;
      if (kind_q == ipv4_fpt_pkg::KindFirst && !(any_hit && first_q[s]))
        ports_q[s] <= iports_q;
    end
    if (cmd_i.load_out) begin
      oh_q <= pend_q ? ph_q : hdata_q;
      od_q <= pend_q ? pd_q : rdisp_q;
      op_ports_q <= pend_q ? pp_q : rports_q;
      ol_q <= pend_q ? pl_q : (rem_q == '0);
    end
    if (cmd_i.decide) begin
      ph_q <= handle_q; rs_q <= (op_q == ipv4_fpt_pkg::OpAge) ? as : s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0; first_q <= '0; pend_q <= 1'b0; more_q <= 1'b0;
      rem_q <= '0; pd_q <= '0; pp_q <= '0; pl_q <= 1'b0;
      rdisp_q <= '0; rports_q <= '0;
      for (int i = 0; i < NS; i++) count_q[i] <= '0;
    end else begin
      if (cmd_i.load_out && pend_q) pend_q <= 1'b0;
      if (cmd_i.pop) begin
        rem_q  <= rem_q - CW'(1);
      end
      if (cmd_i.load_out && !pend_q) more_q <= (rem_q != '0);
      if (cmd_i.decide) begin
        pend_q <= 1'b0; more_q <= 1'b0;
        pp_q <= '0; pd_q <= ipv4_fpt_pkg::DispDrop; pl_q <= 1'b1;
        if (op_q == ipv4_fpt_pkg::OpAge) begin
          if (stale) begin
            valid_q[as] <= 1'b0; first_q[as] <= 1'b0; count_q[as] <= '0;
            rem_q <= count_q[as]; more_q <= count_q[as] != '0;
            rdisp_q <= ipv4_fpt_pkg::DispAged; rports_q <= '0;
          end
        end else if (!any_hit && !any_free) begin
          pend_q <= 1'b1;
        end else begin
          if (!any_hit) begin
            valid_q[s] <= 1'b1; first_q[s] <= 1'b0; count_q[s] <= '0;
          end
          if (kind_q == ipv4_fpt_pkg::KindFirst) begin
            pend_q <= 1'b1;
            if (!(any_hit && first_q[s])) begin
              first_q[s] <= 1'b1; count_q[s] <= '0;
              pd_q <= ipv4_fpt_pkg::DispForward; pp_q <= iports_q;
              rem_q <= any_hit ? count_q[s] : '0;
              more_q <= any_hit && count_q[s] != '0;
              pl_q <= !(any_hit && count_q[s] != '0);
              rdisp_q <= ipv4_fpt_pkg::DispForward; rports_q <= iports_q;
            end
          end else if (kind_q == ipv4_fpt_pkg::KindLater) begin
            if (any_hit && first_q[s]) begin
              pend_q <= 1'b1; pd_q <= ipv4_fpt_pkg::DispForward; pp_q <= ports_q[s];
            end else if (any_hit && count_q[s] >= CW'(ipv4_fpt_pkg::HoldLimit)) begin
              pend_q <= 1'b1;
            end else begin
              count_q[s] <= any_hit ? count_q[s] + CW'(1) : CW'(1);
            end
          end else begin
            pend_q <= 1'b1;
          end
        end
      end
    end
  end

endmodule

/* design/ipv4_fpt_ctrl.sv */
// ----------------------------------------------------------------------------
// IPv4 fragment port tracker controller
// Sequences capture, lookup, decision and result release.
// ----------------------------------------------------------------------------
module ipv4_fpt_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ipv4_fpt_pkg::ctl_cmd_t cmd_o,
  input  ipv4_fpt_pkg::ctl_sts_t sts_i
);
  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StLook   = 6'b000010,
    StDecide = 6'b000100,
    StRoute  = 6'b001000,
    StPop    = 6'b010000,
    StWait   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;

  assign in_ready  = (state_q == StIdle);
  assign out_valid = ovalid_q;

  logic out_free;
  assign out_free = !ovalid_q || out_ready;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q && !out_ready;
    cmd_o    = '0;
    case (state_q)
      StIdle: begin
        if (in_valid) begin
          cmd_o.capture = 1'b1;
          state_d = StLook;
        end
      end
      StLook:   state_d = StDecide;
      StDecide: begin
        cmd_o.decide = 1'b1;
        state_d = StRoute;
      end
      StRoute: begin
        if (sts_i.has_first) begin
          if (out_free) begin
            cmd_o.load_out = 1'b1; ovalid_d = 1'b1;
            state_d = sts_i.more ? StPop : StIdle;
          end
        end else begin
          state_d = sts_i.more ? StPop : StIdle;
        end
      end
      StPop: begin
        cmd_o.pop = 1'b1;
        state_d = StWait;
      end
      StWait: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1; ovalid_d = 1'b1;
          state_d = StRoute;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

/* design/ipv4_fpt_checker.sv */
// ----------------------------------------------------------------------------
// IPv4 fragment port tracker checker
// Port-level properties of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
module ipv4_fpt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  disposition_o,
  input logic [15:0] out_source_port_o,
  input logic [15:0] out_dest_port_o,
  input logic        last_of_run_o
);
  a_disp_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> disposition_o <= ipv4_fpt_pkg::DispAged) else $error("bad disposition");
  a_zero_ports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && disposition_o != ipv4_fpt_pkg::DispForward |-> out_source_port_o == 16'd0 &&
    out_dest_port_o == 16'd0) else $error("ports on non-forward");
  a_no_accept_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("back-to-back accept");
  a_out_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(last_of_run_o))
    else $error("output dropped");
endmodule

bind ipv4_fragment_port_tracker_top ipv4_fpt_checker u_chk (
  .clk_i, .rst_ni, .in_valid, .in_ready, .out_valid, .out_ready,
  .disposition_o, .out_source_port_o, .out_dest_port_o, .last_of_run_o
);

/* dv/tb_ipv4_fragment_port_tracker_top.sv */
// ----------------------------------------------------------------------------
// IPv4 fragment port tracker testbench
// Directed table walk, then random flows under several age timeouts and
// handshake pressures. A flow-table predictor queues expected beats and each
// output beat is checked field by field.
// ----------------------------------------------------------------------------
module tb_ipv4_fragment_port_tracker_top;
  import ipv4_fpt_pkg::*;

  localparam logic [1:0] KindBadLo  = 2'd2;
  localparam logic [1:0] KindBadHi  = 2'd3;
  localparam int         IdleLimit  = 3000;
  localparam int         HoldCycles = 400;
  localparam int         KeyPool    = 20;

  typedef struct packed {
    logic [15:0] ident;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  proto;
  } flow_key_t;

  typedef struct packed {
    logic        op;
    logic [1:0]  kind;
    logic [15:0] handle;
    flow_key_t   key;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] now;
    logic [3:0]  slot;
  } frag_item_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [1:0]  disp;
    logic [15:0] sport;
    logic [15:0] dport;
    logic        last;
  } port_result_t;

  typedef struct packed {
    logic         typed;
    port_result_t res;
  } item_tag_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic        operation_i;
  logic [1:0]  frag_kind_i;
  logic [15:0] packet_handle_i, packet_ident_i, source_port_i, dest_port_i;
  logic [31:0] source_address_i, dest_address_i, now_time_i, cfg_data_i;
  logic [7:0]  protocol_number_i;
  logic [3:0]  slot_index_i;
  logic [15:0] out_handle_o, out_source_port_o, out_dest_port_o;
  logic [1:0]  disposition_o;
  logic        last_of_run_o;

  ipv4_fragment_port_tracker_top dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor copy of the flow table
  logic [31:0] age_limit;
  logic        tbl_valid [TableSlots];
  flow_key_t   tbl_key   [TableSlots];
  logic [31:0] tbl_touch [TableSlots];
  logic        tbl_first [TableSlots];
  logic [31:0] tbl_ports [TableSlots];
  int          tbl_held  [TableSlots];
  logic [15:0] tbl_stack [TableSlots][HoldLimit];

  port_result_t port_expect_q[$];
  item_tag_t    tag_q[$];
  int errors = 0;
  int sender_idle = 0, receiver_idle = 0;
  bit hold_go = 0;
  int idle_count = 0;
  logic [31:0] clock_now = 32'd100;
  flow_key_t   flows[KeyPool];

  function automatic port_result_t mk_res(logic [15:0] h, logic [1:0] d, logic [31:0] p);
    port_result_t r;
    r.handle = h; r.disp = d; r.sport = p[31:16]; r.dport = p[15:0]; r.last = 1'b0;
    return r;
  endfunction

  task automatic track_item(input frag_item_t it, ref port_result_t rq[$]);
    int s;
    s = -1;
    if (it.op == OpAge) begin
      s = it.slot;
      if (s >= TableSlots || !tbl_valid[s]) return;
      if (!(it.now > tbl_touch[s] && (it.now - tbl_touch[s]) > age_limit)) return;
      for (int i = tbl_held[s] - 1; i >= 0; i--) rq.push_back(mk_res(tbl_stack[s][i], DispAged, 0));
      tbl_valid[s] = 0; tbl_first[s] = 0; tbl_held[s] = 0;
    end else begin
      for (int i = 0; i < TableSlots; i++)
        if (s < 0 && tbl_valid[i] && tbl_key[i] == it.key) s = i;
      if (s < 0) begin
        for (int i = 0; i < TableSlots; i++)
          if (s < 0 && !tbl_valid[i]) s = i;
        if (s < 0) begin
          rq.push_back(mk_res(it.handle, DispDrop, 0));
        end else begin
          tbl_valid[s] = 1; tbl_key[s] = it.key; tbl_first[s] = 0;
          tbl_ports[s] = 0; tbl_held[s] = 0;
        end
      end
      if (s >= 0) begin
        tbl_touch[s] = it.now;
        if (it.kind == KindFirst) begin
          if (tbl_first[s]) begin
            rq.push_back(mk_res(it.handle, DispDrop, 0));
          end else begin
            tbl_ports[s] = {it.sport, it.dport};
            rq.push_back(mk_res(it.handle, DispForward, tbl_ports[s]));
            for (int i = tbl_held[s] - 1; i >= 0; i--)
              rq.push_back(mk_res(tbl_stack[s][i], DispForward, tbl_ports[s]));
            tbl_held[s] = 0;
            tbl_first[s] = 1;
          end
        end else if (it.kind == KindLater) begin
          if (tbl_first[s]) rq.push_back(mk_res(it.handle, DispForward, tbl_ports[s]));
          else if (tbl_held[s] >= HoldLimit) rq.push_back(mk_res(it.handle, DispDrop, 0));
          else begin
            tbl_stack[s][tbl_held[s]] = it.handle;
            tbl_held[s]++;
          end
        end else begin
          rq.push_back(mk_res(it.handle, DispDrop, 0));
        end
      end
    end
    if (rq.size() > 0) rq[rq.size() - 1].last = 1'b1;
  endtask

  // monitor: predict on input beats, check output beats
  always @(posedge clk_i) begin
    port_result_t rq[$];
    frag_item_t it;
    item_tag_t tg;
    port_result_t e;
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_count = 0;
      else
        idle_count++;
      if (cfg_valid && cfg_ready) age_limit = cfg_data_i;
      if (in_valid && in_ready) begin
        it = '{operation_i, frag_kind_i, packet_handle_i,
               '{packet_ident_i, source_address_i, dest_address_i, protocol_number_i},
               source_port_i, dest_port_i, now_time_i, slot_index_i};
        rq.delete();
        track_item(it, rq);
        tg = tag_q.pop_front();
        if (tg.typed) begin
          rq.delete();
          rq.push_back(tg.res);
        end
        foreach (rq[i]) port_expect_q.push_back(rq[i]);
      end
      if (out_valid && out_ready) begin
        if (port_expect_q.size() == 0) begin
          $error("unexpected result beat, handle %h", out_handle_o);
          errors++;
        end else begin
          e = port_expect_q.pop_front();
          if (out_handle_o !== e.handle) begin
            $error("out_handle exp %h got %h", e.handle, out_handle_o); errors++;
          end
          if (disposition_o !== e.disp) begin
            $error("disposition exp %h got %h", e.disp, disposition_o); errors++;
          end
          if (out_source_port_o !== e.sport) begin
            $error("out_source_port exp %h got %h", e.sport, out_source_port_o); errors++;
          end
          if (out_dest_port_o !== e.dport) begin
            $error("out_dest_port exp %h got %h", e.dport, out_dest_port_o); errors++;
          end
          if (last_of_run_o !== e.last) begin
            $error("last_of_run exp %h got %h", e.last, last_of_run_o); errors++;
          end
        end
      end
      if (idle_count >= IdleLimit) begin
        $display("ipv4_fragment_port_tracker_top regression: fail");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_taken) begin
        hold_taken = 1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_idle);
      end
    end
  end

  task automatic send_item(input frag_item_t it, input item_tag_t tg);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    operation_i <= it.op;            frag_kind_i <= it.kind;
    packet_handle_i <= it.handle;    packet_ident_i <= it.key.ident;
    source_address_i <= it.key.src;  dest_address_i <= it.key.dst;
    protocol_number_i <= it.key.proto;
    source_port_i <= it.sport;       dest_port_i <= it.dport;
    now_time_i <= it.now;            slot_index_i <= it.slot;
    in_valid <= 1'b1;
    tag_q.push_back(tg);
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic drain_and_write(input logic [31:0] value);
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (port_expect_q.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);  // items without results may still be in flight
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic frag_item_t frag(logic [1:0] kind, logic [15:0] h, flow_key_t k,
                                      logic [31:0] ports, logic [31:0] now);
    frag_item_t it;
    it = '{OpFragment, kind, h, k, ports[31:16], ports[15:0], now, 4'd0};
    return it;
  endfunction

  function automatic frag_item_t age(logic [3:0] slot, logic [31:0] now);
    frag_item_t it;
    it = '0;
    it.op = OpAge; it.slot = slot; it.now = now;
    return it;
  endfunction

  function automatic frag_item_t random_item();
    frag_item_t it;
    int r;
    clock_now += $urandom_range(1, 30);
    if ($urandom_range(19) == 0) clock_now = $urandom;
    if ($urandom_range(99) < 15)
      return age(4'($urandom_range(15)), clock_now + $urandom_range(200));
    r = $urandom_range(99);
    it = frag(r < 50 ? KindLater : r < 85 ? KindFirst : ($urandom_range(1) ? KindBadLo : KindBadHi),
              16'($urandom), flows[$urandom_range(KeyPool - 1)], $urandom, clock_now);
    return it;
  endfunction

  initial begin
    frag_item_t dir_items[$];
    item_tag_t  dir_tags[$];
    flow_key_t  ka, kb, kc, kd;
    item_tag_t  plain;
    logic [31:0] phase_limit[5] = '{32'hFFFF_FFFF, 32'd0, 32'd60, 32'd25, 32'd1000};
    int phase_sidle[5] = '{0, 77, 0, 20, 0};
    int phase_ridle[5] = '{0, 0, 77, 20, 0};

    in_valid = 0; cfg_valid = 0; cfg_data_i = '0;
    operation_i = 0; frag_kind_i = 0; packet_handle_i = 0; packet_ident_i = 0;
    source_address_i = 0; dest_address_i = 0; protocol_number_i = 0;
    source_port_i = 0; dest_port_i = 0; now_time_i = 0; slot_index_i = 0;
    age_limit = AgeTimeoutReset;
    for (int i = 0; i < TableSlots; i++) begin
      tbl_valid[i] = 0; tbl_first[i] = 0; tbl_held[i] = 0;
    end
    plain = '0;

    ka = '{16'h0001, 32'h0A00_0001, 32'h0A00_0002, 8'd6};
    kb = '{16'h0000, 32'h0000_0000, 32'h0000_0000, 8'd0};
    kc = '{16'h1234, 32'hC0A8_0101, 32'hC0A8_0102, 8'd17};
    kd = '{16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF};

    // invalid kinds still claim a slot
    dir_items.push_back(frag(KindBadLo, 16'h0000, ka, 0, 32'd10));
    dir_tags.push_back('{1'b1, '{16'h0000, DispDrop, 16'h0, 16'h0, 1'b1}});
    dir_items.push_back(frag(KindBadHi, 16'hFFFF, kb, 0, 32'd11));
    dir_tags.push_back('{1'b1, '{16'hFFFF, DispDrop, 16'h0, 16'h0, 1'b1}});
    // held laters released newest first by the first fragment
    dir_items.push_back(frag(KindLater, 16'h0010, kc, 0, 32'd12));  dir_tags.push_back(plain);
    dir_items.push_back(frag(KindLater, 16'h0011, kc, 0, 32'd13));  dir_tags.push_back(plain);
    dir_items.push_back(frag(KindFirst, 16'h0012, kc, 32'hFFFF_0000, 32'd14));
    dir_tags.push_back(plain);
    dir_items.push_back(frag(KindFirst, 16'h0013, kc, 32'h1111_2222, 32'd15));
    dir_tags.push_back('{1'b1, '{16'h0013, DispDrop, 16'h0, 16'h0, 1'b1}});
    dir_items.push_back(frag(KindLater, 16'h0014, kc, 0, 32'd16));  dir_tags.push_back(plain);
    dir_items.push_back(frag(KindFirst, 16'h0015, ka, 32'h0000_FFFF, 32'd17));
    dir_tags.push_back('{1'b1, '{16'h0015, DispForward, 16'h0000, 16'hFFFF, 1'b1}});
    // hold fills, ninth later is dropped
    for (int i = 0; i < HoldLimit; i++) begin
      dir_items.push_back(frag(KindLater, 16'(16'hFFF0 + i), kd, 0, 32'd20));
      dir_tags.push_back(plain);
    end
    dir_items.push_back(frag(KindLater, 16'hABCD, kd, 0, 32'd21));
    dir_tags.push_back('{1'b1, '{16'hABCD, DispDrop, 16'h0, 16'h0, 1'b1}});
    dir_items.push_back(age(4'd3, 32'hFFFF_FFFF));  dir_tags.push_back(plain);
    dir_items.push_back(age(4'd15, 32'hFFFF_FFFF)); dir_tags.push_back(plain);
    dir_items.push_back(age(4'd0, 32'd200));        dir_tags.push_back(plain);
    dir_items.push_back(age(4'd2, 32'd0));          dir_tags.push_back(plain);
    // stale slot with nothing held frees silently
    dir_items.push_back(age(4'd1, 32'hFFFF_FFFF));  dir_tags.push_back(plain);

    flows[0] = kd;
    flows[1] = kb;
    for (int i = 2; i < KeyPool; i++)
      flows[i] = '{16'($urandom), $urandom, $urandom, 8'($urandom)};
    flows[3] = flows[2];
    flows[3].proto = ~flows[2].proto;  // near miss on one key field

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_items[i]) send_item(dir_items[i], dir_tags[i]);

    for (int p = 0; p < 5; p++) begin
      drain_and_write(phase_limit[p]);
      sender_idle = phase_sidle[p];
      receiver_idle = phase_ridle[p];
      if (p == 4) hold_go = 1;
      repeat (40) send_item(random_item(), plain);
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (port_expect_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && port_expect_q.size() == 0)
      $display("ipv4_fragment_port_tracker_top regression: pass");
    else
      $display("ipv4_fragment_port_tracker_top regression: fail");
    $finish;
  end

endmodule
